[hdl/hbm_pkg.sv]
package hbm_pkg;

  localparam int MaxKeys = 1024;
  localparam int KeyW    = $clog2(MaxKeys);
  localparam int IdxW    = 10;
  localparam int DistW   = 9;
  localparam int CfgW    = 9;
  localparam int CntW    = 11;
  localparam int PcW     = 7;

  localparam logic [DistW-1:0] DistNone = 9'h1FF;
  localparam logic [DistW-1:0] DistMax  = 9'd256;
  localparam logic [CfgW-1:0]  RatioRst = 9'd230;
  localparam logic [CfgW-1:0]  ThreshRst = 9'd50;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CAND  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    CFG_RATIO  = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_t;

  // One queued item: the descriptor is already reduced to word popcounts.
  typedef struct packed {
    func_t                      func;
    logic [IdxW-1:0]            qidx;
    logic [IdxW-1:0]            cidx;
    logic                       last;
    logic [3:0][PcW-1:0]        pc;
  } hbm_item_t;

  // One target table entry.
  typedef struct packed {
    logic [DistW-1:0] tdist;
    logic             own_v;
    logic [IdxW-1:0]  owner;
  } tgt_entry_t;

  localparam int EntryW = $bits(tgt_entry_t);

  function automatic logic [5:0] pop32(input logic [31:0] x);
    logic [31:0] v;
    logic [31:0] b;
    begin
      v = x - ((x >> 1) & 32'h5555_5555);
      v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
      b = (v + (v >> 4)) & 32'h0F0F_0F0F;
      pop32 = 6'(b[7:0] + b[15:8] + b[23:16] + b[31:24]);
    end
  endfunction

  function automatic logic [PcW-1:0] pop64(input logic [63:0] x);
    pop64 = PcW'(pop32(x[31:0])) + PcW'(pop32(x[63:32]));
  endfunction

endpackage

[hdl/hbm_in_if.sv]
interface hbm_in_if import hbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [IdxW-1:0]  query_index;
  logic [IdxW-1:0]  cand_index;
  logic [63:0]      desc_word0;
  logic [63:0]      desc_word1;
  logic [63:0]      desc_word2;
  logic [63:0]      desc_word3;
  logic             last;

  modport source (output valid, func, query_index, cand_index, desc_word0, desc_word1,
                  desc_word2, desc_word3, last, input ready);
  modport sink (input valid, func, query_index, cand_index, desc_word0, desc_word1,
                desc_word2, desc_word3, last, output ready);
endinterface

[hdl/hbm_out_if.sv]
interface hbm_out_if import hbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  query_id;
  logic             matched;
  logic [IdxW-1:0]  matched_index;
  logic [DistW-1:0] match_distance;
  logic             revoked;
  logic [IdxW-1:0]  revoked_query;
  logic [CntW-1:0]  match_total;

  modport source (output valid, query_id, matched, matched_index, match_distance, revoked,
                  revoked_query, match_total, input ready);
  modport sink (input valid, query_id, matched, matched_index, match_distance, revoked,
                revoked_query, match_total, output ready);
endinterface

[hdl/hbm_ram.sv]
module hbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata_r
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

[hdl/hbm_front.sv]
module hbm_front import hbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hbm_in_if.sink    in_ch,
  input  logic      clearing,
  input  logic      q_pop,
  output logic      q_valid,
  output hbm_item_t q_head
);

  logic [3:0][63:0] qdesc_r, qdesc_nxt;
  hbm_item_t        q_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  hbm_item_t        item;

  assign in_ch.ready = (cnt_r != 2'd2) && !clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_head      = q_r[rd_ptr_r];

  // Classify the item and reduce the candidate distance to word popcounts.
  always_comb begin
    item.func = func_t'(in_ch.func);
    item.qidx = in_ch.query_index;
    item.cidx = in_ch.cand_index;
    item.last = in_ch.last;
    item.pc[0] = pop64(qdesc_r[0] ^ in_ch.desc_word0);
    item.pc[1] = pop64(qdesc_r[1] ^ in_ch.desc_word1);
    item.pc[2] = pop64(qdesc_r[2] ^ in_ch.desc_word2);
    item.pc[3] = pop64(qdesc_r[3] ^ in_ch.desc_word3);
  end

  // A query item replaces the stored descriptor for later candidates.
  always_comb begin
    qdesc_nxt = qdesc_r;
    if (push && (func_t'(in_ch.func) == FUNC_QUERY)) begin
      qdesc_nxt = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0};
    end
  end

  // Queue pointers.
  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qdesc_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      qdesc_r  <= qdesc_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

[hdl/hbm_back.sv]
module hbm_back import hbm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  input  logic            q_valid,
  input  hbm_item_t       q_head,
  output logic            q_pop,
  output logic            clearing,
  hbm_out_if.source       out_ch
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CMP   = 4'b0100,
    S_DEC   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CfgW-1:0]   ratio_r, ratio_nxt;
  logic [CfgW-1:0]   thresh_r, thresh_nxt;
  logic [IdxW-1:0]   cur_q_r, cur_q_nxt;
  logic [DistW-1:0]  best_r, best_nxt;
  logic [DistW-1:0]  second_r, second_nxt;
  logic [IdxW-1:0]   bt_r, bt_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [KeyW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [DistW-1:0]  d_r, d_nxt;
  logic [IdxW-1:0]   cidx_r, cidx_nxt;
  logic              last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IdxW-1:0]   o_qid_r, o_qid_nxt;
  logic              o_m_r, o_m_nxt;
  logic [IdxW-1:0]   o_mi_r, o_mi_nxt;
  logic [DistW-1:0]  o_md_r, o_md_nxt;
  logic              o_rv_r, o_rv_nxt;
  logic [IdxW-1:0]   o_rq_r, o_rq_nxt;
  logic [CntW-1:0]   o_tot_r, o_tot_nxt;

  logic              ram_we, ram_re;
  logic [KeyW-1:0]   ram_waddr, ram_raddr;
  tgt_entry_t        ram_wdata, ram_rdata;
  logic [DistW-1:0]  head_d;
  logic [17:0]       second_scaled;
  logic              accept;
  logic              rev;
  logic              out_free;

  hbm_ram #(.Width(EntryW), .Depth(MaxKeys)) u_tbl (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign clearing = (state_r == S_CLEAR);
  assign out_free = !out_valid_r || out_ch.ready;
  assign head_d   = DistW'(q_head.pc[0]) + DistW'(q_head.pc[1])
                  + DistW'(q_head.pc[2]) + DistW'(q_head.pc[3]);

  // Ratio test and ownership of the best target, from the entry read for it.
  assign second_scaled = second_r * ratio_r;
  always_comb begin
    accept = (best_r <= DistMax) && (best_r <= thresh_r);
    if (accept && (second_r <= DistMax)) begin
      accept = ({1'b0, best_r, 8'd0} <= second_scaled);
    end
    rev = accept && ram_rdata.own_v;
  end

  // Sequencer for clearing, candidate compare and the decision.
  always_comb begin
    state_nxt     = state_r;
    ratio_nxt     = ratio_r;
    thresh_nxt    = thresh_r;
    cur_q_nxt     = cur_q_r;
    best_nxt      = best_r;
    second_nxt    = second_r;
    bt_nxt        = bt_r;
    cnt_nxt       = cnt_r;
    clr_addr_nxt  = clr_addr_r;
    d_nxt         = d_r;
    cidx_nxt      = cidx_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_qid_nxt     = o_qid_r;
    o_m_nxt       = o_m_r;
    o_mi_nxt      = o_mi_r;
    o_md_nxt      = o_md_r;
    o_rv_nxt      = o_rv_r;
    o_rq_nxt      = o_rq_r;
    o_tot_nxt     = o_tot_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr_r;
    ram_wdata     = '{tdist: DistNone, own_v: 1'b0, owner: '0};
    ram_re        = 1'b0;
    ram_raddr     = KeyW'(q_head.cidx);

    if (cfg_we) begin
      if (cfg_idx_t'(cfg_index) == CFG_RATIO) begin
        ratio_nxt = cfg_wdata;
      end else begin
        thresh_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (32'(clr_addr_r) == MaxKeys - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          d_nxt    = head_d;
          cidx_nxt = q_head.cidx;
          last_nxt = q_head.last;
          unique case (q_head.func)
            FUNC_CLEAR: begin
              cnt_nxt      = '0;
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            FUNC_QUERY: begin
              cur_q_nxt  = q_head.qidx;
              best_nxt   = DistNone;
              second_nxt = DistNone;
              bt_nxt     = '0;
            end
            FUNC_CAND: begin
              if (32'(q_head.cidx) < MaxKeys) begin
                ram_re    = 1'b1;
                state_nxt = S_CMP;
              end else if (q_head.last) begin
                ram_re    = 1'b1;
                ram_raddr = KeyW'(bt_r);
                state_nxt = S_DEC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        // Only a candidate that improves on its target's recorded distance counts.
        if (ram_rdata.tdist > d_r) begin
          if (d_r < best_r) begin
            second_nxt = best_r;
            best_nxt   = d_r;
            bt_nxt     = cidx_r;
          end else if (d_r < second_r) begin
            second_nxt = d_r;
          end
        end
        if (last_r) begin
          ram_re    = 1'b1;
          ram_raddr = KeyW'(bt_nxt);
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEC: begin
        if (out_free) begin
          if (accept) begin
            ram_we    = 1'b1;
            ram_waddr = KeyW'(bt_r);
            ram_wdata = '{tdist: best_r, own_v: 1'b1, owner: cur_q_r};
            cnt_nxt   = cnt_r - CntW'(rev && (cnt_r != '0)) + 1'b1;
          end
          out_valid_nxt = 1'b1;
          o_qid_nxt     = cur_q_r;
          o_m_nxt       = accept;
          o_mi_nxt      = accept ? bt_r : '0;
          o_md_nxt      = accept ? best_r : '0;
          o_rv_nxt      = rev;
          o_rq_nxt      = rev ? ram_rdata.owner : '0;
          o_tot_nxt     = accept ? cnt_r - CntW'(rev && (cnt_r != '0)) + 1'b1 : cnt_r;
          best_nxt      = DistNone;
          second_nxt    = DistNone;
          bt_nxt        = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ratio_r     <= RatioRst;
      thresh_r    <= ThreshRst;
      cur_q_r     <= '0;
      best_r      <= DistNone;
      second_r    <= DistNone;
      bt_r        <= '0;
      cnt_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_r     <= ratio_nxt;
      thresh_r    <= thresh_nxt;
      cur_q_r     <= cur_q_nxt;
      best_r      <= best_nxt;
      second_r    <= second_nxt;
      bt_r        <= bt_nxt;
      cnt_r       <= cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    cidx_r  <= cidx_nxt;
    last_r  <= last_nxt;
    o_qid_r <= o_qid_nxt;
    o_m_r   <= o_m_nxt;
    o_mi_r  <= o_mi_nxt;
    o_md_r  <= o_md_nxt;
    o_rv_r  <= o_rv_nxt;
    o_rq_r  <= o_rq_nxt;
    o_tot_r <= o_tot_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.query_id       = o_qid_r;
  assign out_ch.matched        = o_m_r;
  assign out_ch.matched_index  = o_mi_r;
  assign out_ch.match_distance = o_md_r;
  assign out_ch.revoked        = o_rv_r;
  assign out_ch.revoked_query  = o_rq_r;
  assign out_ch.match_total    = o_tot_r;

endmodule

[hdl/hamming_best_two_match_ratio_top.sv]
// Channel   Dir   Moves
// in_ch     in    one request: clear, load query or compare candidate
// out_ch    out   one decision per candidate marked last
// cfg_*     in    register write, index 0 ratio_q8, index 1 dist_threshold
//
// In the back end a candidate takes a target table read, then a compare.
// A last candidate adds a decision step that reads and writes the best target's entry.
// Query and unused requests are handled in the back-end idle state; the front queue holds two requests.
// After reset and on each clear request all 1024 entries of the target table are swept,
// with in_ch.ready low. Synchronous active-low reset; both sides may stall freely.
module hamming_best_two_match_ratio_top import hbm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  hbm_in_if.sink          in_ch,
  hbm_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  logic      q_valid;
  logic      q_pop;
  logic      clearing;
  hbm_item_t q_head;

  hbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  hbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_ch    (out_ch)
  );

endmodule

[hdl/hbm_checker.sv]
module hbm_checker import hbm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             matched,
  input logic [IdxW-1:0]  matched_index,
  input logic [DistW-1:0] match_distance,
  input logic             revoked,
  input logic [CntW-1:0]  match_total
);

  // A pending decision stays offered until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("decision dropped while stalled");

  // The table sweep after reset blocks new requests.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during table sweep");

  // A rejected query reports no target and no distance.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !matched |-> (matched_index == '0) && (match_distance == '0))
    else $error("rejected decision carries a target");

  // A revoke only happens with a new match, so the total is at least one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && revoked |-> matched && (match_total != '0))
    else $error("revoke without match");

endmodule

bind hamming_best_two_match_ratio_top hbm_checker u_hbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .matched        (out_ch.matched),
  .matched_index  (out_ch.matched_index),
  .match_distance (out_ch.match_distance),
  .revoked        (out_ch.revoked),
  .match_total    (out_ch.match_total)
);

[tb/sv/hamming_best_two_match_ratio_top_tb.sv]
`timescale 1ns / 100ps

module hamming_best_two_match_ratio_top_tb;
  import hbm_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]  query_id;
    logic             matched;
    logic [IdxW-1:0]  matched_index;
    logic [DistW-1:0] match_distance;
    logic             revoked;
    logic [IdxW-1:0]  revoked_query;
    logic [CntW-1:0]  match_total;
  } decision_t;

  typedef struct {
    func_t            func;
    logic [IdxW-1:0]  qidx;
    logic [IdxW-1:0]  cidx;
    logic [3:0][63:0] desc;
    logic             last;
  } request_t;

  localparam int CycleLimit = 2000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CfgW-1:0] cfg_wdata;

  hbm_in_if  in_ch ();
  hbm_out_if out_ch ();

  hamming_best_two_match_ratio_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow state of the matcher.
  logic [CfgW-1:0]  sh_ratio;
  logic [CfgW-1:0]  sh_thresh;
  logic [3:0][63:0] sh_query_desc;
  logic [IdxW-1:0]  sh_query;
  logic [DistW-1:0] sh_best;
  logic [DistW-1:0] sh_second;
  logic [IdxW-1:0]  sh_best_tgt;
  logic [DistW-1:0] sh_tgt_dist [MaxKeys];
  logic             sh_own_v [MaxKeys];
  logic [IdxW-1:0]  sh_owner [MaxKeys];
  int unsigned      sh_count;

  decision_t pending_decisions[$];
  int unsigned mismatches;
  int unsigned decisions_seen;
  int unsigned requests_sent;
  int unsigned accepts_seen;
  int unsigned revokes_seen;
  longint unsigned cycle_count;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned hamming256(logic [3:0][63:0] a, logic [3:0][63:0] b);
    logic [255:0] x;
    int unsigned n;
    x = a ^ b;
    n = 0;
    for (int i = 0; i < 256; i++) n += x[i];
    return n;
  endfunction

  task automatic clear_shadow_tables();
    for (int i = 0; i < MaxKeys; i++) begin
      sh_tgt_dist[i] = DistNone;
      sh_own_v[i] = 1'b0;
      sh_owner[i] = '0;
    end
    sh_count = 0;
  endtask

  task automatic clear_search();
    sh_best = DistNone;
    sh_second = DistNone;
    sh_best_tgt = '0;
  endtask

  // Updates the shadow state for one accepted request and queues any decision.
  task automatic predict_match(request_t r);
    int unsigned d;
    bit ok;
    decision_t e;
    case (r.func)
      FUNC_CLEAR: clear_shadow_tables();
      FUNC_QUERY: begin
        sh_query_desc = r.desc;
        sh_query = r.qidx;
        clear_search();
      end
      FUNC_CAND: begin
        d = hamming256(sh_query_desc, r.desc);
        if (sh_tgt_dist[r.cidx] > d) begin
          if (d < sh_best) begin
            sh_second = sh_best;
            sh_best = DistW'(d);
            sh_best_tgt = r.cidx;
          end else if (d < sh_second) begin
            sh_second = DistW'(d);
          end
        end
        if (r.last) begin
          e = '0;
          ok = sh_best <= DistMax && sh_best <= sh_thresh;
          if (ok && sh_second <= DistMax)
            ok = (int'(sh_best) * 256) <= (int'(sh_second) * int'(sh_ratio));
          if (ok) begin
            if (sh_own_v[sh_best_tgt]) begin
              e.revoked = 1'b1;
              e.revoked_query = sh_owner[sh_best_tgt];
              if (sh_count > 0) sh_count--;
            end
            sh_own_v[sh_best_tgt] = 1'b1;
            sh_owner[sh_best_tgt] = sh_query;
            sh_tgt_dist[sh_best_tgt] = sh_best;
            sh_count++;
            e.matched = 1'b1;
            e.matched_index = sh_best_tgt;
            e.match_distance = sh_best;
          end
          e.query_id = sh_query;
          e.match_total = CntW'(sh_count > 2047 ? 2047 : sh_count);
          pending_decisions = {pending_decisions, e};
          clear_search();
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  // Sends one request, predicting its outcome when the handshake completes.
  // Valid stays high between back-to-back requests and drops only before a gap.
  task automatic send_request(request_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.query_index <= r.qidx;
    in_ch.cand_index <= r.cidx;
    in_ch.desc_word0 <= r.desc[0];
    in_ch.desc_word1 <= r.desc[1];
    in_ch.desc_word2 <= r.desc[2];
    in_ch.desc_word3 <= r.desc[3];
    in_ch.last <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_match(r);
    requests_sent++;
  endtask

  function automatic logic [255:0] rand_desc();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  // Flips randomly chosen bits, as many times as asked, so that distances spread over a useful range.
  function automatic logic [255:0] near_desc(logic [255:0] base, int unsigned flips);
    logic [255:0] v;
    v = base;
    for (int i = 0; i < flips; i++) v[$urandom_range(0, 255)] ^= 1'b1;
    return v;
  endfunction

  function automatic request_t make_req(func_t f, int unsigned q, int unsigned c,
                                        logic [255:0] d, bit l);
    request_t r;
    r.func = f;
    r.qidx = IdxW'(q);
    r.cidx = IdxW'(c);
    r.desc = d;
    r.last = l;
    return r;
  endfunction

  // Waits until every decision is back and the block has been quiet for a while,
  // so that no clear sweep or queued request is still in flight.
  task automatic wait_idle();
    int unsigned quiet;
    in_ch.valid <= 1'b0;
    quiet = 0;
    while (quiet < 16) begin
      @(posedge clk);
      if (in_ch.ready && pending_decisions.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RATIO) sh_ratio = val;
    else sh_thresh = val;
  endtask

  // Result side: random stalls and an in-order comparison.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_decision();
      out_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                      ($urandom_range(0, 3) != 0);
    end
  end

  task automatic check_decision();
    decision_t got;
    decision_t want;
    got.query_id = out_ch.query_id;
    got.matched = out_ch.matched;
    got.matched_index = out_ch.matched_index;
    got.match_distance = out_ch.match_distance;
    got.revoked = out_ch.revoked;
    got.revoked_query = out_ch.revoked_query;
    got.match_total = out_ch.match_total;
    decisions_seen++;
    if (pending_decisions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected decision: %p", got);
      return;
    end
    want = pending_decisions.pop_front();
    if (got.matched) accepts_seen++;
    if (got.revoked) revokes_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Decision mismatch at cycle %0d:\n  expected %p\n  actual   %p",
                 cycle_count, want, got);
    end
  endtask

  // Extremes of the descriptor, unused func code, the highest candidate index and empty queries.
  task automatic test_directed();
    logic [255:0] q;
    q = '0;
    send_request(make_req(FUNC_CAND, 0, 5, '1, 1'b1));
    send_request(make_req(FUNC_QUERY, 1023, 0, q, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 0, '1, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 1023, q, 1'b1));
    send_request(make_req(FUNC_NONE, 17, 9, '1, 1'b1));
    send_request(make_req(FUNC_QUERY, 3, 0, '1, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 1023, '1, 1'b1));
    send_request(make_req(FUNC_QUERY, 4, 0, '1, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 1023, near_desc('1, 10), 1'b1));
    send_request(make_req(FUNC_QUERY, 0, 0, '1, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 7, near_desc('1, 5), 1'b0));
    send_request(make_req(FUNC_CAND, 0, 8, near_desc('1, 40), 1'b0));
    send_request(make_req(FUNC_CAND, 0, 9, '1, 1'b1));
    // A descriptor with every bit flipped.
    send_request(make_req(FUNC_QUERY, 5, 0, q, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 100, '1, 1'b1));
    send_request(make_req(FUNC_CLEAR, 0, 0, q, 1'b0));
    send_request(make_req(FUNC_CAND, 0, 100, q, 1'b1));
    wait_idle();
  endtask

  // Well-formed query groups with random content, some noise and clears.
  task automatic test_random(int unsigned n_items);
    logic [255:0] base;
    int unsigned n;
    int unsigned ncand;
    int unsigned pick;
    n = 0;
    while (n < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(make_req(FUNC_CLEAR, $urandom, $urandom, rand_desc(), 1'($urandom)));
        n++;
      end else if (pick < 6) begin
        send_request(make_req(FUNC_NONE, $urandom, $urandom, rand_desc(), 1'($urandom)));
      end else if (pick < 10) begin
        send_request(make_req(FUNC_CAND, $urandom, $urandom_range(0, 31), rand_desc(),
                              1'($urandom)));
        n++;
      end else begin
        base = rand_desc();
        send_request(make_req(FUNC_QUERY, $urandom_range(0, 1023), $urandom, base, 1'b0));
        ncand = $urandom_range(1, 6);
        for (int i = 0; i < ncand; i++)
          send_request(make_req(FUNC_CAND, $urandom, $urandom_range(0, 31),
                                near_desc(base, $urandom_range(0, 80)), i == ncand - 1));
        n += ncand + 1;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RATIO;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_CLEAR;
    in_ch.query_index = '0;
    in_ch.cand_index = '0;
    in_ch.desc_word0 = '0;
    in_ch.desc_word1 = '0;
    in_ch.desc_word2 = '0;
    in_ch.desc_word3 = '0;
    in_ch.last = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    decisions_seen = 0;
    requests_sent = 0;
    accepts_seen = 0;
    revokes_seen = 0;
    sh_ratio = RatioRst;
    sh_thresh = ThreshRst;
    sh_query_desc = '0;
    sh_query = '0;
    clear_search();
    clear_shadow_tables();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    write_reg(CFG_THRESH, 9'd256);
    write_reg(CFG_RATIO, 9'd256);
    test_directed();
    write_reg(CFG_THRESH, 9'd0);
    write_reg(CFG_RATIO, 9'd0);
    test_directed();
    write_reg(CFG_THRESH, 9'd60);
    write_reg(CFG_RATIO, 9'd200);
    test_random(200);
    write_reg(CFG_THRESH, 9'd256);
    write_reg(CFG_RATIO, 9'd256);
    test_random(150);
    write_reg(CFG_THRESH, 9'd511);
    write_reg(CFG_RATIO, 9'd511);
    test_random(75);
    write_reg(CFG_THRESH, 9'd20);
    write_reg(CFG_RATIO, 9'd128);
    test_random(75);

    if (pending_decisions.size() != 0) begin
      mismatches++;
      $display("%0d decisions never arrived.", pending_decisions.size());
    end
    $display("Sent %0d requests, checked %0d decisions (%0d accepted, %0d revoked).",
             requests_sent, decisions_seen, accepts_seen, revokes_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
